@@ rtl/lat_pkg.sv @@
// Shared types and constants for the live allocation tracker.
package lat_pkg;

    localparam int ADDR_W = 64;
    localparam int SIZE_W = 48;
    localparam int SUM_W  = 64;

    // Operation codes carried in the func field.
    typedef logic [1:0] lat_func_t;
    localparam lat_func_t FUNC_ALLOC = 2'd0;
    localparam lat_func_t FUNC_FREE  = 2'd1;
    localparam lat_func_t FUNC_CLEAR = 2'd2;

    // One table entry as stored in the RAM.
    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] address;
        logic [SIZE_W-1:0] size;
    } lat_entry_t;

    // Status flags reported by the table scanner.
    typedef struct packed {
        logic done;
        logic hit;
        logic free_ok;
    } lat_scan_flags_t;

    // Sequencer states, one-hot.
    typedef enum logic [4:0] {
        ST_CLEAR  = 5'b00001,
        ST_IDLE   = 5'b00010,
        ST_SCAN   = 5'b00100,
        ST_UPDATE = 5'b01000,
        ST_OUT    = 5'b10000
    } lat_state_t;

endpackage

@@ rtl/lat_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module lat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/lat_scan.sv @@
// Table scanner: walks the entry RAM one slot per cycle through a single comparator.
module lat_scan #(
    parameter int DEPTH = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [lat_pkg::ADDR_W-1:0]  key,
    output logic                        rd_en,
    output logic [$clog2(DEPTH)-1:0]    rd_addr,
    input  lat_pkg::lat_entry_t         rd_data,
    output lat_pkg::lat_scan_flags_t    flags,
    output logic [$clog2(DEPTH)-1:0]    hit_idx,
    output logic [lat_pkg::SIZE_W-1:0]  hit_size,
    output logic [$clog2(DEPTH)-1:0]    free_idx
);
    import lat_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam logic [IW-1:0] LAST = IW'(DEPTH - 1);

    logic              issuing_reg;
    logic              pend_reg;
    logic [IW-1:0]     scan_idx_reg;
    logic [IW-1:0]     cmp_idx_reg;
    logic              free_ok_reg;
    logic [IW-1:0]     free_idx_reg;
    logic              hit_reg;
    logic [IW-1:0]     hit_idx_reg;
    logic [SIZE_W-1:0] hit_size_reg;
    logic              done_reg;

    logic match;
    logic empty;
    logic last_cmp;

    // The one shared comparator: the entry read last cycle against the key.
    assign match    = pend_reg && rd_data.valid && (rd_data.address == key);
    assign empty    = pend_reg && !rd_data.valid;
    assign last_cmp = pend_reg && (cmp_idx_reg == LAST);

    assign rd_en    = issuing_reg;
    assign rd_addr  = scan_idx_reg;

    assign flags.done    = done_reg;
    assign flags.hit     = hit_reg;
    assign flags.free_ok = free_ok_reg;
    assign hit_idx  = hit_idx_reg;
    assign hit_size = hit_size_reg;
    assign free_idx = free_idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issuing_reg  <= 1'b0;
            pend_reg     <= 1'b0;
            scan_idx_reg <= '0;
            cmp_idx_reg  <= '0;
            free_ok_reg  <= 1'b0;
            free_idx_reg <= '0;
            hit_reg      <= 1'b0;
            hit_idx_reg  <= '0;
            hit_size_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                issuing_reg  <= 1'b1;
                pend_reg     <= 1'b0;
                scan_idx_reg <= '0;
                free_ok_reg  <= 1'b0;
                hit_reg      <= 1'b0;
            end
            else
            begin
                pend_reg <= issuing_reg;
                if (issuing_reg)
                begin
                    cmp_idx_reg <= scan_idx_reg;
                    if (scan_idx_reg == LAST)
                    begin
                        issuing_reg <= 1'b0;
                    end
                    else
                    begin
                        scan_idx_reg <= scan_idx_reg + 1'b1;
                    end
                end
                if (match)
                begin
                    // Addresses are unique in the table, so the first hit ends the walk.
                    hit_reg      <= 1'b1;
                    hit_idx_reg  <= cmp_idx_reg;
                    hit_size_reg <= rd_data.size;
                    issuing_reg  <= 1'b0;
                    pend_reg     <= 1'b0;
                    done_reg     <= 1'b1;
                end
                else
                begin
                    if (empty && !free_ok_reg)
                    begin
                        free_ok_reg  <= 1'b1;
                        free_idx_reg <= cmp_idx_reg;
                    end
                    if (last_cmp)
                    begin
                        done_reg <= 1'b1;
                    end
                end
            end
        end
    end

endmodule

@@ rtl/live_allocation_tracker_unit.sv @@
// Top level of the live allocation tracker: sequencer, totals and output register.

// The tracker holds a table of TABLE_DEPTH live allocations (address and size) in one
// RAM and keeps wrapping 64-bit totals of bytes allocated, freed and still live. Each
// request on the s_ side produces exactly one result on the m_ side. An alloc or free
// request walks the table one slot per cycle through a single address comparator; the walk
// stops early when the address is found. A clear request rewrites every slot, one per
// cycle. After reset the block runs the same clearing pass before s_tready first rises.
// Only one request is in flight at a time; s_tready is high while the block is idle, and
// a finished result may wait in the output register while the next request is taken. A
// new address goes to the lowest free slot; if there is none, table_full is set and
// nothing changes. func code 3 changes nothing and reports the current totals.
module live_allocation_tracker_unit #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // func [1:0], address [65:2], block_size [113:66], zero fill [119:114]
    input  logic [119:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // allocated_total [63:0], freed_total [127:64], live_total [191:128],
    // entry_found [192], table_full [193], released_size [241:194], zero fill [247:242]
    output logic [247:0] m_tdata
);
    import lat_pkg::*;

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam logic [IW-1:0] LAST = IW'(TABLE_DEPTH - 1);

    // Sequencer state and the request being worked on.
    lat_state_t        state_reg, state_next;
    lat_func_t         func_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [SIZE_W-1:0] size_reg;
    logic [IW-1:0]     clr_idx_reg;
    logic              clr_pend_reg;

    // Running totals.
    logic [SUM_W-1:0]  alloc_sum_reg;
    logic [SUM_W-1:0]  freed_sum_reg;
    logic [SUM_W-1:0]  live_sum_reg;

    // Result flags gathered during the update step.
    logic              res_found_reg;
    logic              res_full_reg;
    logic [SIZE_W-1:0] res_released_reg;

    // Output register.
    logic              m_valid_reg;
    logic [247:0]      m_data_reg;

    // RAM ports.
    logic              ram_we;
    logic [IW-1:0]     ram_waddr;
    lat_entry_t        ram_wdata;
    logic              ram_re;
    logic [IW-1:0]     ram_raddr;
    lat_entry_t        ram_rdata;

    // Scanner interface.
    logic              scan_start;
    lat_scan_flags_t   scan_flags;
    logic [IW-1:0]     hit_idx;
    logic [SIZE_W-1:0] hit_size;
    logic [IW-1:0]     free_idx;

    logic              in_accept;
    logic              out_load;
    logic              do_store;
    logic              do_remove;
    logic [SUM_W-1:0]  amount;

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    // A result moves into the output register once the previous one has been taken.
    assign out_load = (state_reg == ST_OUT) && (!m_valid_reg || m_tready);

    assign scan_start = in_accept &&
                        ((s_tdata[1:0] == FUNC_ALLOC) || (s_tdata[1:0] == FUNC_FREE));

    // An alloc is stored over its own entry on a hit, otherwise in the lowest free slot.
    assign do_store  = (state_reg == ST_UPDATE) && (func_reg == FUNC_ALLOC) &&
                       (scan_flags.hit || scan_flags.free_ok);
    assign do_remove = (state_reg == ST_UPDATE) && (func_reg == FUNC_FREE) && scan_flags.hit;
    assign amount    = (func_reg == FUNC_ALLOC) ? {{(SUM_W - SIZE_W){1'b0}}, size_reg}
                                                : {{(SUM_W - SIZE_W){1'b0}}, hit_size};

    // The clearing sweep and the update step share the single write port.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = clr_idx_reg;
        ram_wdata = '0;
        if (state_reg == ST_CLEAR)
        begin
            ram_we = 1'b1;
        end
        else if (do_store || do_remove)
        begin
            ram_we            = 1'b1;
            ram_waddr         = scan_flags.hit ? hit_idx : free_idx;
            ram_wdata.valid   = do_store;
            ram_wdata.address = addr_reg;
            ram_wdata.size    = size_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_idx_reg == LAST)
                begin
                    state_next = clr_pend_reg ? ST_OUT : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (scan_start)
                    begin
                        state_next = ST_SCAN;
                    end
                    else if (s_tdata[1:0] == FUNC_CLEAR)
                    begin
                        state_next = ST_CLEAR;
                    end
                    else
                    begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_SCAN:
            begin
                if (scan_flags.done)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_idx_reg   <= '0;
            clr_pend_reg  <= 1'b0;
            alloc_sum_reg <= '0;
            freed_sum_reg <= '0;
            live_sum_reg  <= '0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (state_reg == ST_CLEAR)
            begin
                clr_idx_reg <= (clr_idx_reg == LAST) ? '0 : clr_idx_reg + 1'b1;
            end

            if (in_accept)
            begin
                clr_idx_reg  <= '0;
                clr_pend_reg <= (s_tdata[1:0] == FUNC_CLEAR);
                if (s_tdata[1:0] == FUNC_CLEAR)
                begin
                    alloc_sum_reg <= '0;
                    freed_sum_reg <= '0;
                    live_sum_reg  <= '0;
                end
            end

            if (do_store)
            begin
                alloc_sum_reg <= alloc_sum_reg + amount;
                live_sum_reg  <= live_sum_reg + amount;
            end
            else if (do_remove)
            begin
                freed_sum_reg <= freed_sum_reg + amount;
                live_sum_reg  <= live_sum_reg - amount;
            end

            if (out_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Request and result payload registers.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            func_reg         <= s_tdata[1:0];
            addr_reg         <= s_tdata[65:2];
            size_reg         <= s_tdata[113:66];
            res_found_reg    <= 1'b0;
            res_full_reg     <= 1'b0;
            res_released_reg <= '0;
        end
        if (state_reg == ST_UPDATE)
        begin
            if (func_reg == FUNC_ALLOC)
            begin
                res_found_reg <= scan_flags.hit;
                res_full_reg  <= !scan_flags.hit && !scan_flags.free_ok;
            end
            else
            begin
                res_found_reg    <= scan_flags.hit;
                res_released_reg <= scan_flags.hit ? hit_size : '0;
            end
        end
        if (out_load)
        begin
            m_data_reg <= {6'b0, res_released_reg, res_full_reg, res_found_reg,
                           live_sum_reg, freed_sum_reg, alloc_sum_reg};
        end
    end

    lat_ram #(
        .WIDTH ($bits(lat_entry_t)),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    lat_scan #(
        .DEPTH (TABLE_DEPTH)
    ) u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (scan_start),
        .key      (addr_reg),
        .rd_en    (ram_re),
        .rd_addr  (ram_raddr),
        .rd_data  (ram_rdata),
        .flags    (scan_flags),
        .hit_idx  (hit_idx),
        .hit_size (hit_size),
        .free_idx (free_idx)
    );

endmodule

@@ rtl/lat_checker.sv @@
// Port-level checker for the live allocation tracker, bound to the top level.
module lat_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [119:0] s_tdata,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [247:0] m_tdata
);

    // A result that is not taken stays put.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Live bytes always equal allocated minus freed, modulo two to the sixty-four.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[191:128] == (m_tdata[63:0] - m_tdata[127:64])))
        else $error("live total does not match allocated minus freed");

    // A request cannot both find its entry and report a full table.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[192] && m_tdata[193]))
        else $error("entry_found and table_full both set");

    // Bytes are only released from an entry that was found.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[241:194] != 48'd0) |-> m_tdata[192])
        else $error("released size without a found entry");

    // Only one request is in flight: the input closes right after a request is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request accepted while busy");

endmodule

bind live_allocation_tracker_unit lat_checker u_lat_checker (.*);

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the live allocation tracker, with its own table and totals.

module testbench;
    import lat_pkg::*;

    localparam int TABLE_DEPTH    = 64;
    localparam int REQUEST_TARGET = 1400;
    localparam int IDLE_PERCENT   = 24;
    localparam int HOLD_CYCLES    = 400;
    localparam int HOLD_AFTER     = 250;
    localparam int PRINT_LIMIT    = 40;

    // func code 3 has no operation behind it; the block reports totals and does nothing.
    localparam lat_func_t FUNC_UNUSED = 2'd3;

    localparam logic [SUM_W-1:0]  ONES_64  = '1;
    localparam logic [SUM_W-1:0]  SIZE_TOP = 64'h0000_FFFF_FFFF_FFFF;
    localparam logic [SUM_W-1:0]  SIZE_WRAP = 64'h0001_0000_0000_0000;
    localparam logic [SIZE_W-1:0] SIZE_ONES = '1;

    // Request as packed into s_tdata, lowest field last.
    typedef struct packed {
        logic [5:0]        fill;
        logic [SIZE_W-1:0] block_size;
        logic [ADDR_W-1:0] address;
        lat_func_t         func;
    } lat_request_t;

    // Result as packed into m_tdata, lowest field last.
    typedef struct packed {
        logic [5:0]        fill;
        logic [SIZE_W-1:0] released_size;
        logic              table_full;
        logic              entry_found;
        logic [SUM_W-1:0]  live_total;
        logic [SUM_W-1:0]  freed_total;
        logic [SUM_W-1:0]  allocated_total;
    } lat_result_t;

    // One row of the directed table; when typed is set, want is the result to see.
    typedef struct {
        lat_func_t         func;
        logic [ADDR_W-1:0] address;
        logic [SIZE_W-1:0] block_size;
        bit                typed;
        lat_result_t       want;
    } directed_row_t;

    logic         clk = 1'b0;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    // func [1:0], address [65:2], block_size [113:66], zero fill [119:114]
    logic [119:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    // allocated_total [63:0], freed_total [127:64], live_total [191:128],
    // entry_found [192], table_full [193], released_size [241:194], zero fill [247:242]
    logic [247:0] m_tdata;

    // The testbench's own copy of the allocation table and the running totals.
    bit                slot_valid [TABLE_DEPTH];
    logic [ADDR_W-1:0] slot_address [TABLE_DEPTH];
    logic [SIZE_W-1:0] slot_size [TABLE_DEPTH];
    logic [SUM_W-1:0]  allocated_sum;
    logic [SUM_W-1:0]  freed_sum;
    logic [SUM_W-1:0]  live_sum;

    // Results still owed by the block, oldest first.
    lat_result_t   pending_results[$];
    directed_row_t directed_rows[$];

    int  error_count;
    int  results_seen;
    int  counted_requests;
    int  alloc_requests;
    int  free_requests;
    int  clear_requests;
    int  unused_requests;
    int  refused_allocs;
    int  address_hits;
    bit  steady_run;

    live_allocation_tracker_unit #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    // 12 ns clock period.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Builds a result for the directed table.
    function automatic lat_result_t typed_result(logic [SUM_W-1:0] allocated,
                                                 logic [SUM_W-1:0] freed,
                                                 logic [SUM_W-1:0] live,
                                                 logic found, logic full,
                                                 logic [SIZE_W-1:0] released);
        lat_result_t r;
        r = '0;
        r.allocated_total = allocated;
        r.freed_total     = freed;
        r.live_total      = live;
        r.entry_found     = found;
        r.table_full      = full;
        r.released_size   = released;
        return r;
    endfunction

    // Returns the slot that holds addr, or -1 when the address is not live.
    function automatic int slot_of(logic [ADDR_W-1:0] addr);
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (slot_valid[i] && slot_address[i] == addr)
                return i;
        end
        return -1;
    endfunction

    function automatic int live_entries();
        int n;
        n = 0;
        for (int i = 0; i < TABLE_DEPTH; i++)
            n += int'(slot_valid[i]);
        return n;
    endfunction

    // Applies one request to the local table and totals and returns the result
    // the block must produce for it.
    function automatic lat_result_t track_request(lat_func_t func, logic [ADDR_W-1:0] addr,
                                                  logic [SIZE_W-1:0] size);
        lat_result_t r;
        int          slot;
        r    = '0;
        slot = slot_of(addr);
        case (func)
            FUNC_ALLOC:
            begin
                alloc_requests++;
                if (slot >= 0)
                begin
                    r.entry_found = 1'b1;
                    address_hits++;
                end
                else
                begin
                    // A new address takes the lowest slot that is not in use.
                    for (int i = TABLE_DEPTH - 1; i >= 0; i--)
                    begin
                        if (!slot_valid[i])
                            slot = i;
                    end
                end
                if (slot < 0)
                begin
                    r.table_full = 1'b1;
                    refused_allocs++;
                end
                else
                begin
                    slot_valid[slot]   = 1'b1;
                    slot_address[slot] = addr;
                    slot_size[slot]    = size;
                    allocated_sum += SUM_W'(size);
                    live_sum      += SUM_W'(size);
                end
            end
            FUNC_FREE:
            begin
                free_requests++;
                if (slot >= 0)
                begin
                    r.entry_found   = 1'b1;
                    r.released_size = slot_size[slot];
                    slot_valid[slot] = 1'b0;
                    freed_sum += SUM_W'(slot_size[slot]);
                    live_sum  -= SUM_W'(slot_size[slot]);
                    address_hits++;
                end
            end
            FUNC_CLEAR:
            begin
                clear_requests++;
                for (int i = 0; i < TABLE_DEPTH; i++)
                    slot_valid[i] = 1'b0;
                allocated_sum = '0;
                freed_sum     = '0;
                live_sum      = '0;
            end
            default:
                unused_requests++;
        endcase
        r.allocated_total = allocated_sum;
        r.freed_total     = freed_sum;
        r.live_total      = live_sum;
        return r;
    endfunction

    // Mostly random 64-bit addresses, with a share of small and high ones so that
    // repeats and every address bit occur.
    function automatic logic [ADDR_W-1:0] fresh_address();
        case ($urandom_range(0, 3))
            0:       return {$urandom, $urandom};
            1:       return ADDR_W'($urandom_range(0, 255));
            2:       return {32'hFFFF_FFFF, $urandom};
            default: return {$urandom, $urandom} & ~64'hF;
        endcase
    endfunction

    function automatic logic [SIZE_W-1:0] random_size();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return SIZE_ONES;
            2, 3, 4: return SIZE_W'($urandom_range(1, 4096));
            default: return SIZE_W'({$urandom, $urandom});
        endcase
    endfunction

    // An address that is live in the table, searched from a random slot; a fresh
    // address when the table is empty.
    function automatic logic [ADDR_W-1:0] pick_live_address();
        int start;
        int k;
        start = $urandom_range(0, TABLE_DEPTH - 1);
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            k = (start + i) % TABLE_DEPTH;
            if (slot_valid[k])
                return slot_address[k];
        end
        return fresh_address();
    endfunction

    task automatic flag_mismatch(string field, logic [SUM_W-1:0] got, logic [SUM_W-1:0] want);
        error_count++;
        if (error_count <= PRINT_LIMIT)
            $display("Mismatch at result %0d, %s: got 0x%0h, wanted 0x%0h",
                     results_seen, field, got, want);
    endtask

    // Offers one request, holding it until the block accepts it, and files the result
    // the block owes for it. Entered and left at a falling edge.
    task automatic send_request(lat_func_t func, logic [ADDR_W-1:0] addr,
                                logic [SIZE_W-1:0] size, bit typed = 1'b0,
                                lat_result_t want = '0);
        lat_result_t predicted;
        lat_request_t request;
        request = '0;
        request.func       = func;
        request.address    = addr;
        request.block_size = size;
        if (func != FUNC_UNUSED)
            counted_requests++;
        // A stretch in the middle of the random part runs with no idle cycles.
        steady_run = (counted_requests >= 600 && counted_requests < 800);
        while (!steady_run && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= request;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        predicted = track_request(func, addr, size);
        pending_results.push_back(typed ? want : predicted);
        @(negedge clk);
    endtask

    // Reset, the directed table, then random episodes of well-formed allocation traffic
    // mixed with table fills and noise.
    initial
    begin
        logic [ADDR_W-1:0] addr;
        int                roll;
        int                episode;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;

        // Directed rows: an unknown free on the empty table, the size and address
        // extremes, an overwrite, a repeated free, the unused code, a free of a zero-size
        // entry, the clear item, and slot reuse after a free.
        directed_rows.push_back('{FUNC_FREE, 64'h0, 48'h0, 1'b1,
                                  typed_result(64'd0, 64'd0, 64'd0, 1'b0, 1'b0, 48'd0)});
        directed_rows.push_back('{FUNC_ALLOC, 64'h0, SIZE_ONES, 1'b1,
                                  typed_result(SIZE_TOP, 64'd0, SIZE_TOP, 1'b0, 1'b0, 48'd0)});
        directed_rows.push_back('{FUNC_ALLOC, ONES_64, 48'h0, 1'b1,
                                  typed_result(SIZE_TOP, 64'd0, SIZE_TOP, 1'b0, 1'b0, 48'd0)});
        directed_rows.push_back('{FUNC_ALLOC, 64'h0, 48'h1, 1'b1,
                                  typed_result(SIZE_WRAP, 64'd0, SIZE_WRAP, 1'b1, 1'b0,
                                               48'd0)});
        directed_rows.push_back('{FUNC_FREE, 64'h0, SIZE_ONES, 1'b1,
                                  typed_result(SIZE_WRAP, 64'd1, SIZE_TOP, 1'b1, 1'b0,
                                               48'h1)});
        directed_rows.push_back('{FUNC_FREE, 64'h0, 48'h0, 1'b1,
                                  typed_result(SIZE_WRAP, 64'd1, SIZE_TOP, 1'b0, 1'b0,
                                               48'd0)});
        directed_rows.push_back('{FUNC_UNUSED, 64'h5555_5555_5555_5555, 48'hAAAA_AAAA_AAAA,
                                  1'b1, typed_result(SIZE_WRAP, 64'd1, SIZE_TOP, 1'b0, 1'b0,
                                                     48'd0)});
        directed_rows.push_back('{FUNC_FREE, ONES_64, 48'h0, 1'b1,
                                  typed_result(SIZE_WRAP, 64'd1, SIZE_TOP, 1'b1, 1'b0,
                                               48'd0)});
        directed_rows.push_back('{FUNC_CLEAR, ONES_64, SIZE_ONES, 1'b1,
                                  typed_result(64'd0, 64'd0, 64'd0, 1'b0, 1'b0, 48'd0)});
        directed_rows.push_back('{FUNC_FREE, ONES_64, 48'h0, 1'b1,
                                  typed_result(64'd0, 64'd0, 64'd0, 1'b0, 1'b0, 48'd0)});
        directed_rows.push_back('{FUNC_ALLOC, 64'h8000_0000_0000_0001, 48'h8000_0000_0000,
                                  1'b0, '0});
        directed_rows.push_back('{FUNC_ALLOC, 64'h1, 48'h1, 1'b0, '0});
        directed_rows.push_back('{FUNC_ALLOC, 64'h8000_0000_0000_0001, 48'h7FFF_FFFF_FFFF,
                                  1'b0, '0});
        directed_rows.push_back('{FUNC_FREE, 64'h1, 48'h0, 1'b0, '0});
        directed_rows.push_back('{FUNC_ALLOC, 64'h2, 48'h3, 1'b0, '0});
        directed_rows.push_back('{FUNC_UNUSED, ONES_64, SIZE_ONES, 1'b0, '0});
        directed_rows.push_back('{FUNC_FREE, 64'h8000_0000_0000_0001, 48'h0, 1'b0, '0});
        directed_rows.push_back('{FUNC_FREE, 64'h2, 48'h0, 1'b0, '0});

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_request(directed_rows[i].func, directed_rows[i].address,
                         directed_rows[i].block_size, directed_rows[i].typed,
                         directed_rows[i].want);

        while (counted_requests < REQUEST_TARGET)
        begin
            episode = $urandom_range(0, 5);
            if (episode <= 2)
            begin
                // Ordinary churn: allocations, overwrites, frees of live and unknown
                // addresses, and now and then a clear or an unused code.
                repeat ($urandom_range(40, 120))
                begin
                    roll = $urandom_range(0, 99);
                    if (roll < 55)
                    begin
                        addr = (live_entries() > 0 && $urandom_range(0, 99) < 30) ?
                               pick_live_address() : fresh_address();
                        send_request(FUNC_ALLOC, addr, random_size());
                    end
                    else if (roll < 93)
                    begin
                        addr = (live_entries() > 0 && $urandom_range(0, 99) < 80) ?
                               pick_live_address() : fresh_address();
                        send_request(FUNC_FREE, addr, random_size());
                    end
                    else if (roll < 96)
                        send_request(FUNC_CLEAR, fresh_address(), random_size());
                    else
                        send_request(FUNC_UNUSED, fresh_address(), random_size());
                end
            end
            else if (episode <= 4)
            begin
                // Fill the table, then push on it while full: refused new addresses,
                // overwrites, and a free followed by a new address that must take the
                // freed slot.
                while (live_entries() < TABLE_DEPTH)
                    send_request(FUNC_ALLOC, fresh_address(), random_size());
                repeat (16)
                begin
                    roll = $urandom_range(0, 99);
                    if (roll < 40)
                        send_request(FUNC_ALLOC, fresh_address(), random_size());
                    else if (roll < 70)
                        send_request(FUNC_ALLOC, pick_live_address(), random_size());
                    else
                    begin
                        send_request(FUNC_FREE, pick_live_address(), random_size());
                        send_request(FUNC_ALLOC, fresh_address(), random_size());
                    end
                end
                if ($urandom_range(0, 1) == 0)
                    send_request(FUNC_CLEAR, fresh_address(), random_size());
            end
            else
            begin
                // Noise: any code, any address, any size.
                repeat ($urandom_range(8, 20))
                begin
                    addr = ($urandom_range(0, 1) == 0) ? pick_live_address() :
                           fresh_address();
                    send_request(lat_func_t'($urandom_range(0, 3)), addr, random_size());
                end
            end
        end
        s_tvalid <= 1'b0;
        steady_run = 1'b0;

        // Drain, then give the block a full table walk to show any stray result.
        wait (pending_results.size() == 0);
        repeat (TABLE_DEPTH + 16) @(posedge clk);

        $display("Run covered %0d allocs, %0d frees, %0d clears and %0d unused codes.",
                 alloc_requests, free_requests, clear_requests, unused_requests);
        $display("%0d results checked, %0d address hits, %0d refused allocs, %0d errors.",
                 results_seen, address_hits, refused_allocs, error_count);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Result side: random stalls, no stalls during the steady stretch, and one long
    // hold-off so that a result waits in the output register and the input backs up.
    initial
    begin
        bit held;
        held     = 1'b0;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!held && results_seen >= HOLD_AFTER)
            begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else
                m_tready <= steady_run || ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    // Every accepted result is matched against the oldest one owed.
    always @(posedge clk)
    begin
        lat_result_t got;
        lat_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = lat_result_t'(m_tdata);
            if (pending_results.size() == 0)
                flag_mismatch("result with no request behind it", got.allocated_total, '0);
            else
            begin
                want = pending_results.pop_front();
                if (got.allocated_total !== want.allocated_total)
                    flag_mismatch("allocated_total", got.allocated_total,
                                  want.allocated_total);
                if (got.freed_total !== want.freed_total)
                    flag_mismatch("freed_total", got.freed_total, want.freed_total);
                if (got.live_total !== want.live_total)
                    flag_mismatch("live_total", got.live_total, want.live_total);
                if (got.entry_found !== want.entry_found)
                    flag_mismatch("entry_found", SUM_W'(got.entry_found),
                                  SUM_W'(want.entry_found));
                if (got.table_full !== want.table_full)
                    flag_mismatch("table_full", SUM_W'(got.table_full),
                                  SUM_W'(want.table_full));
                if (got.released_size !== want.released_size)
                    flag_mismatch("released_size", SUM_W'(got.released_size),
                                  SUM_W'(want.released_size));
                if (got.fill !== 6'd0)
                    flag_mismatch("zero fill", SUM_W'(got.fill), '0);
            end
            results_seen++;
        end
    end

    // Hard stop, several times the slowest correct run.
    initial
    begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
